@@ rtl/nnss_pkg.sv @@
// ----------------------------------------------------------------------------
// nnss_pkg
// Shared types and constants for the nearest-neighbour scale stepper.
// ----------------------------------------------------------------------------
package nnss_pkg;

  // Default coordinate width (skip / error term); position is one bit wider.
  localparam int COORD_BITS_DEFAULT = 15;

  // Length registers are 16 bits wide.
  localparam int REG_W = 16;

  // APB map: word index taken from paddr[2].
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_SRC = 1'b0;
  localparam logic REG_IDX_DST = 1'b1;

  // Input op codes (carried in s_tuser).
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_N,
    ST_DIV_S,
    ST_DONE
  } nnss_state_t;

endpackage

@@ rtl/nearest_neighbour_scale_stepper.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbour_scale_stepper
// One axis of a nearest-neighbour scaler, stepped by an integer DDA.
// ----------------------------------------------------------------------------
// An advance beat (op = 1) moves one destination pixel; a new advance beat
// can be accepted every cycle while the serial unit is idle and the result
// beat is drained. A start beat (op = 0) runs through a single bit-serial
// unit that first forms source_length * skip by shift-and-add, then divides
// it by the clamped destination length in a restoring divider, then divides
// source_length by the same divisor, and hands the result over once the
// result register is free. The lengths are sampled at start; writes made
// later take effect at the next start. The result beat carries the source
// position (saturating at 2^(COORD_BITS+1)-1), the error term and a changed
// flag that is set after every start and whenever the position moved.
// ----------------------------------------------------------------------------
module nearest_neighbour_scale_stepper #(
  parameter int COORD_BITS = nnss_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Input stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // tdata: [COORD_BITS-1:0] skip, rest zero padding
  input  logic [((COORD_BITS+7)/8)*8-1:0]         s_tdata,
  // tuser: [0] op
  input  logic                                    s_tuser,
  // Result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // tdata: [COORD_BITS:0] position, then COORD_BITS bits error_term, padding
  output logic [((2*COORD_BITS+1+7)/8)*8-1:0]     m_tdata,
  // tuser: [0] changed
  output logic                                    m_tuser,
  // APB configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [nnss_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [nnss_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [nnss_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  localparam int CB     = COORD_BITS;
  localparam int PW     = COORD_BITS + 1;          // position width
  localparam int DW     = COORD_BITS + 1;          // divisor width
  localparam int RW     = nnss_pkg::REG_W;
  localparam int NW     = RW + COORD_BITS;         // product / dividend width
  localparam int CW     = $clog2(NW);
  localparam int XW     = (PW > RW) ? PW : RW;
  localparam int OUT_DW = ((2*COORD_BITS+1+7)/8)*8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RW-1:0] source_length;
  logic [RW-1:0] destination_length;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_length      <= RW'(1);
      destination_length <= RW'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == nnss_pkg::REG_IDX_SRC) begin
        source_length <= pwdata[RW-1:0];
      end else begin
        destination_length <= pwdata[RW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == nnss_pkg::REG_IDX_SRC) begin
      prdata = nnss_pkg::CFG_DATA_W'(source_length);
    end else begin
      prdata = nnss_pkg::CFG_DATA_W'(destination_length);
    end
  end

  // --------------------------------------------------------------------------
  // Axis state
  // --------------------------------------------------------------------------
  nnss_pkg::nnss_state_t state, state_next;

  logic [PW-1:0] current_position;
  logic [CB-1:0] error_accumulator;
  logic [PW-1:0] whole_step;
  logic [CB-1:0] step_remainder;
  logic          previous_valid;   // previous position is always current_position
  logic [DW-1:0] div_lat;
  logic [RW-1:0] src_lat;

  // Serial unit
  logic [NW-1:0] dvd;              // product, then dividend shift register
  logic [CB-1:0] skip_sh;          // multiplier bits, MSB first
  logic [CB-1:0] rem;              // partial remainder
  logic [RW-1:0] quo;              // quotient shift register
  logic [CW-1:0] cnt;

  // Output register
  logic [PW-1:0] out_pos;
  logic [CB-1:0] out_err;
  logic          out_chg;

  // Handshake
  logic out_free;
  logic in_fire;
  logic start_fire;
  logic adv_fire;
  logic out_load;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == nnss_pkg::ST_IDLE) && out_free;
  assign in_fire    = s_tvalid && s_tready;
  assign start_fire = in_fire && (s_tuser == nnss_pkg::OP_START);
  assign adv_fire   = in_fire && (s_tuser == nnss_pkg::OP_ADVANCE);
  assign out_load   = (state == nnss_pkg::ST_DONE) && out_free;

  // Saturate a 16-bit quotient to the position range.
  function automatic logic [PW-1:0] sat_q(input logic [RW-1:0] q);
    logic [XW-1:0] qx;
    logic [XW-1:0] mx;
    qx = XW'(q);
    mx = XW'({PW{1'b1}});
    return (qx > mx) ? {PW{1'b1}} : PW'(qx);
  endfunction

  // Divisor and skip clamps for a start beat
  logic [31:0]   dst_ext;
  logic [31:0]   div_max;
  logic [DW-1:0] div_c;
  logic [CB-1:0] skip_in;
  logic [CB-1:0] skip_c;

  assign dst_ext = 32'(destination_length);
  assign div_max = 32'(1) << CB;
  assign skip_in = s_tdata[CB-1:0];

  always_comb begin
    if (dst_ext == 32'd0) begin
      div_c = DW'(1);
    end else if (dst_ext > div_max) begin
      div_c = DW'(div_max);
    end else begin
      div_c = DW'(dst_ext);
    end
    skip_c = (DW'(skip_in) >= div_c) ? CB'(div_c - DW'(1)) : skip_in;
  end

  // One shift-and-add step
  logic [NW-1:0] prod_step;
  assign prod_step = (dvd << 1) + (skip_sh[CB-1] ? NW'(src_lat) : NW'(0));

  // One restoring division step
  logic [DW-1:0] trial;
  logic          q_bit;
  logic [CB-1:0] rem_step;
  logic [RW-1:0] quo_step;

  assign trial    = {rem, dvd[NW-1]};
  assign q_bit    = (trial >= div_lat);
  assign rem_step = CB'(q_bit ? (trial - div_lat) : trial);
  assign quo_step = {quo[RW-2:0], q_bit};

  // Advance: one DDA step
  logic [PW:0]   pos_sum;
  logic [DW-1:0] err_sum;
  logic          wrap;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] pos_adv;
  logic [CB-1:0] err_adv;

  assign pos_sum = {1'b0, current_position} + {1'b0, whole_step};
  assign err_sum = {1'b0, error_accumulator} + {1'b0, step_remainder};
  assign wrap    = (err_sum >= div_lat);
  assign err_adv = CB'(wrap ? (err_sum - div_lat) : err_sum);
  assign pos_inc = pos_sum + (PW+1)'(wrap);
  assign pos_adv = pos_inc[PW] ? {PW{1'b1}} : pos_inc[PW-1:0];

  // Phase ends
  logic mul_last;
  logic divn_last;
  logic divs_last;

  assign mul_last  = (cnt == CW'(CB - 1));
  assign divn_last = (cnt == CW'(NW - 1));
  assign divs_last = (cnt == CW'(RW - 1));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      nnss_pkg::ST_IDLE: begin
        if (start_fire) state_next = nnss_pkg::ST_MUL;
      end
      nnss_pkg::ST_MUL: begin
        if (mul_last) state_next = nnss_pkg::ST_DIV_N;
      end
      nnss_pkg::ST_DIV_N: begin
        if (divn_last) state_next = nnss_pkg::ST_DIV_S;
      end
      nnss_pkg::ST_DIV_S: begin
        if (divs_last) state_next = nnss_pkg::ST_DONE;
      end
      nnss_pkg::ST_DONE: begin
        if (out_free) state_next = nnss_pkg::ST_IDLE;
      end
      default: state_next = nnss_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      current_position  <= '0;
      error_accumulator <= '0;
      whole_step        <= '0;
      step_remainder    <= '0;
      previous_valid    <= 1'b0;
      div_lat           <= DW'(1);
      cnt               <= '0;
    end else begin
      case (state)
        nnss_pkg::ST_IDLE: begin
          if (start_fire) begin
            div_lat        <= div_c;
            src_lat        <= source_length;
            skip_sh        <= skip_c;
            dvd            <= '0;
            cnt            <= '0;
            previous_valid <= 1'b1;
          end else if (adv_fire) begin
            current_position  <= pos_adv;
            error_accumulator <= err_adv;
            previous_valid    <= 1'b1;
          end
        end
        nnss_pkg::ST_MUL: begin
          dvd     <= prod_step;
          skip_sh <= skip_sh << 1;
          if (mul_last) begin
            cnt <= '0;
            rem <= '0;
            quo <= '0;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        nnss_pkg::ST_DIV_N: begin
          if (divn_last) begin
            current_position  <= sat_q(quo_step);
            error_accumulator <= rem_step;
            // reload with the source length, MSB-aligned, for the step divide
            dvd <= {src_lat, {CB{1'b0}}};
            rem <= '0;
            quo <= '0;
            cnt <= '0;
          end else begin
            rem <= rem_step;
            quo <= quo_step;
            dvd <= dvd << 1;
            cnt <= cnt + CW'(1);
          end
        end
        nnss_pkg::ST_DIV_S: begin
          rem <= rem_step;
          quo <= quo_step;
          dvd <= dvd << 1;
          cnt <= cnt + CW'(1);
          if (divs_last) begin
            whole_step     <= sat_q(quo_step);
            step_remainder <= rem_step;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_fire || out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_fire) begin
      out_pos <= pos_adv;
      out_err <= err_adv;
      out_chg <= !previous_valid || (pos_adv != current_position);
    end else if (out_load) begin
      out_pos <= current_position;
      out_err <= error_accumulator;
      out_chg <= 1'b1;
    end
  end

  assign m_tdata = OUT_DW'({out_err, out_pos});
  assign m_tuser = out_chg;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_below_div: assert property (@(posedge clk) disable iff (rst)
    state == nnss_pkg::ST_IDLE |-> ({1'b0, error_accumulator} < div_lat))
    else $error("error term not below divisor");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == nnss_pkg::ST_IDLE |-> ({1'b0, step_remainder} < div_lat))
    else $error("step remainder not below divisor");

  a_start_changed: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && m_tuser))
    else $error("start result without changed flag");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_lat != '0)
    else $error("latched divisor is zero");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    start_fire |=> !s_tready)
    else $error("input accepted while serial unit busy");

endmodule
